/* rtl/core/lfu_pkg.sv */
// Package for the LFU cache with LRU tie-break.
// Holds sizes, the controller/datapath command and status structs.
package lfu_pkg;
    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
    localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SCAN,
        CMD_TOUCH,
        CMD_EVICT,
        CMD_INSERT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [IDX_W-1:0]   idx;
    } dp_cmd_t;

    typedef struct packed {
        logic               hit;
        logic               full;
        logic               cap_zero;
        logic               victim_found;
        logic [31:0]        hit_value;
    } dp_status_t;
endpackage

/* rtl/core/lfu_cache_lru_tiebreak.sv */
// LFU cache with LRU tie-break, top level.
// Instantiates lfu_ctrl and lfu_datapath; depends on lfu_pkg.
//
// Usage: one request on s_axis (req_type in tuser, key/value in tdata),
// one response on m_axis (hit in tuser, read_value in tdata).
// A request is taken only while the block is idle. It scans all 16
// entries one per cycle, then does one pass over all entries to update
// ranks/counts on a hit, or up to two passes (evict then insert) on a
// put miss; a get miss or a zero-capacity put does no pass. The next
// request is taken the cycle after the response is taken.
// Throughput is set by the sequential scan and update passes.
// The response is held in an output register until m_axis_tready;
// while stalled no request is accepted.
// Reset (aresetn low, synchronous) empties the store and sets capacity
// to 16. cfg_we writes capacity; write only when idle.
module lfu_cache_lru_tiebreak (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,      // capacity
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] key, [63:32] value
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // read_value
    output logic        m_axis_tuser    // hit
);
    import lfu_pkg::*;

    logic [4:0]  capacity_reg;
    dp_cmd_t     cmd;
    dp_status_t  status;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            capacity_reg <= 5'd16;
        else if (cfg_we)
            capacity_reg <= cfg_wdata;
    end

    lfu_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_put    (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_hit   (m_axis_tuser),
        .out_value (m_axis_tdata),
        .cmd       (cmd),
        .status    (status)
    );

    lfu_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .req_put   (s_axis_tuser),
        .req_key   (s_axis_tdata[31:0]),
        .req_value (s_axis_tdata[63:32]),
        .capacity  (capacity_reg),
        .status    (status)
    );
endmodule

/* rtl/core/lfu_datapath.sv */
// Datapath of the LFU cache: entry store, sequential scan for key match
// and eviction victim, rank updates. Depends on lfu_pkg.
module lfu_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  lfu_pkg::dp_cmd_t    cmd,
    input  logic                req_put,
    input  logic [31:0]         req_key,
    input  logic [31:0]         req_value,
    input  logic [4:0]          capacity,
    output lfu_pkg::dp_status_t status
);
    import lfu_pkg::*;

    logic [ENTRIES-1:0]  valid_reg;
    logic [31:0]         key_reg   [ENTRIES];
    logic [31:0]         value_reg [ENTRIES];
    logic [31:0]         count_reg [ENTRIES];
    logic [IDX_W-1:0]    rank_reg  [ENTRIES];
    logic [CNT_W-1:0]    filled_reg;

    logic                put_reg;
    logic [31:0]         rkey_reg;
    logic [31:0]         rval_reg;
    logic                hit_reg;
    logic [IDX_W-1:0]    slot_reg;
    logic [IDX_W-1:0]    slot_rank_reg;
    logic                vfound_reg;
    logic [IDX_W-1:0]    victim_reg;
    logic                free_found_reg;

    logic [CNT_W-1:0]    cap_clamped;
    logic                vbetter;
    logic [IDX_W-1:0]    i;

    assign i = cmd.idx;
    assign cap_clamped = (capacity > 5'(ENTRIES)) ? CNT_W'(ENTRIES) : CNT_W'(capacity);
    assign vbetter = !vfound_reg || (count_reg[i] < count_reg[victim_reg]) ||
                     (count_reg[i] == count_reg[victim_reg] &&
                      rank_reg[i] > rank_reg[victim_reg]);

    assign status.hit          = hit_reg;
    assign status.full         = filled_reg >= cap_clamped;
    assign status.cap_zero     = cap_clamped == '0;
    assign status.victim_found = vfound_reg;
    assign status.hit_value    = value_reg[slot_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            filled_reg <= '0;
        end else begin
            unique case (cmd.op)
                CMD_LOAD: begin
                    put_reg        <= req_put;
                    rkey_reg       <= req_key;
                    rval_reg       <= req_value;
                    hit_reg        <= 1'b0;
                    vfound_reg     <= 1'b0;
                    free_found_reg <= 1'b0;
                end
                CMD_SCAN: begin
                    if (valid_reg[i]) begin
                        if (!hit_reg && key_reg[i] == rkey_reg) begin
                            hit_reg       <= 1'b1;
                            slot_reg      <= i;
                            slot_rank_reg <= rank_reg[i];
                        end
                        if (vbetter) begin
                            vfound_reg <= 1'b1;
                            victim_reg <= i;
                        end
                    end
                end
                CMD_TOUCH: begin
                    if (i == slot_reg) begin
                        rank_reg[i] <= '0;
                        if (count_reg[i] != COUNT_MAX)
                            count_reg[i] <= count_reg[i] + 32'd1;
                        if (put_reg)
                            value_reg[i] <= rval_reg;
                    end else if (valid_reg[i] && rank_reg[i] < slot_rank_reg) begin
                        rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                    end
                end
                CMD_EVICT: begin
                    if (i == victim_reg) begin
                        valid_reg[i] <= 1'b0;
                        if (filled_reg != '0)
                            filled_reg <= filled_reg - CNT_W'(1);
                    end else if (valid_reg[i] && rank_reg[i] > rank_reg[victim_reg]) begin
                        rank_reg[i] <= rank_reg[i] - IDX_W'(1);
                    end
                end
                CMD_INSERT: begin
                    // one pass: bump ranks of valid entries, claim first free slot
                    if (valid_reg[i]) begin
                        rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                    end else if (!free_found_reg) begin
                        free_found_reg <= 1'b1;
                        valid_reg[i]   <= 1'b1;
                        key_reg[i]     <= rkey_reg;
                        value_reg[i]   <= rval_reg;
                        count_reg[i]   <= 32'd1;
                        rank_reg[i]    <= '0;
                        filled_reg     <= filled_reg + CNT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

/* rtl/core/lfu_ctrl.sv */
// Controller of the LFU cache: sequences load, scan and update passes
// and owns the handshakes. Depends on lfu_pkg.
module lfu_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_put,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_hit,
    output logic [31:0]         out_value,
    output lfu_pkg::dp_cmd_t    cmd,
    input  lfu_pkg::dp_status_t status
);
    import lfu_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_DECIDE, ST_TOUCH, ST_EVICT, ST_INSERT, ST_OUT
    } state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              put_reg;
    logic              last;

    assign last     = idx_reg == IDX_W'(ENTRIES - 1);
    assign in_ready = state_reg == ST_IDLE;

    always_comb begin
        cmd.idx = idx_reg;
        unique case (state_reg)
            ST_IDLE:   cmd.op = (in_valid) ? CMD_LOAD : CMD_NONE;
            ST_SCAN:   cmd.op = CMD_SCAN;
            ST_TOUCH:  cmd.op = CMD_TOUCH;
            ST_EVICT:  cmd.op = CMD_EVICT;
            ST_INSERT: cmd.op = CMD_INSERT;
            default:   cmd.op = CMD_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid <= 1'b0;
            idx_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (in_valid) begin
                    put_reg   <= in_put;
                    idx_reg   <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (last)
                        state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    out_hit   <= status.hit;
                    out_value <= put_reg ? 32'd0 :
                                 (status.hit ? status.hit_value : MISS_VALUE);
                    idx_reg   <= '0;
                    priority if (put_reg && status.cap_zero)
                        state_reg <= ST_OUT;
                    else if (status.hit)
                        state_reg <= ST_TOUCH;
                    else if (!put_reg)
                        state_reg <= ST_OUT;
                    else if (status.full && status.victim_found)
                        state_reg <= ST_EVICT;
                    else
                        state_reg <= ST_INSERT;
                end
                ST_TOUCH, ST_INSERT: begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (last)
                        state_reg <= ST_OUT;
                end
                ST_EVICT: begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (last)
                        state_reg <= ST_INSERT;
                end
                ST_OUT: begin
                    out_valid <= 1'b1;
                    if (out_valid && out_ready) begin
                        out_valid <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

/* rtl/core/lfu_checker.sv */
// Port-level checker for the LFU cache; bound to lfu_cache_lru_tiebreak.
// Depends on nothing else.
module lfu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    // no new request while a response waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready during response");
    // a request never yields a response the next cycle
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("early response");
    // stalled response holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("response dropped");
    // a miss gives all ones (get) or zero (put)
    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser && m_axis_tdata != 32'hFFFF_FFFF)
        |-> m_axis_tdata == 32'd0) else $error("bad miss value");
endmodule

bind lfu_cache_lru_tiebreak lfu_checker u_chk (.*);
